// File: rtl/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg: cosine similarity engine shared definitions
// Element, accumulator, root and quotient widths and the saturation limits
// used by the accumulate, square root and divide datapath.
// ----------------------------------------------------------------------------
package cse_pkg;

    // element and vector length
    localparam int ELEM_W  = 16;
    localparam int MAX_LEN = 512;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    // accumulators and square roots (ACC_W even)
    localparam int ACC_W  = 40;
    localparam int ROOT_W = ACC_W / 2;

    // shared multiplier: signed operands wide enough for elements and roots
    localparam int MUL_W  = (ELEM_W + 1 > ROOT_W + 1) ? ELEM_W + 1 : ROOT_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SUM_W  = PROD_W + 1;

    // shared subtractor for root and quotient steps
    localparam int REM_W = ACC_W + 1;
    localparam int SUB_W = ACC_W + 2;

    // result format
    localparam int OUT_W     = 16;
    localparam int DIV_STEPS = OUT_W;
    localparam int ITER_W    = $clog2(ROOT_W);

    // stream payload widths
    localparam int S_DATA_W = ((2 * ELEM_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int M_USER_W = 2;

    // saturation limits in the width of the accumulate adder
    localparam logic signed [SUM_W-1:0] DOT_MAX =
        {{(SUM_W - ACC_W + 1){1'b0}}, {(ACC_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] DOT_MIN =
        {{(SUM_W - ACC_W + 1){1'b1}}, {(ACC_W - 1){1'b0}}};
    localparam logic signed [SUM_W-1:0] NORM_MAX =
        {{(SUM_W - ACC_W){1'b0}}, {ACC_W{1'b1}}};

    // result limits
    localparam logic [OUT_W-1:0] SIM_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam logic [OUT_W-1:0] SIM_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

    // first digit weight of the bitwise square root
    localparam logic [ACC_W-1:0] ROOT_BIT_INIT = {2'b01, {(ACC_W - 2){1'b0}}};

endpackage

// File: rtl/cosine_similarity_engine.sv
// ----------------------------------------------------------------------------
// cosine_similarity_engine: streaming cosine similarity of two vectors
// Accumulates dot product and squared norms of element pairs, then on the
// last pair computes dot / (sqrt(normA) * sqrt(normB)) in signed Q1.15.
// ----------------------------------------------------------------------------
//
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------------
//  s_       | in        | tdata: elem_a, elem_b; tlast: last_pair
//  m_       | out       | tdata: similarity; tuser: zero_norm, length_error
//
// A pair that is not last is accepted, then a*a, b*b, a*b go through the
// one shared multiplier and are accumulated; a pair past the length limit
// is accepted and dropped. A last pair adds two 20-step square roots and a
// 16-step divide on one shared subtractor, plus check, denominator, divide
// setup, saturate and result steps (no divide if saturated at setup, only
// check and result for zero norm or length error), then the result handshake.
// Reset (aresetn low, synchronous) clears the sequencer, accumulators, count
// and output valid. A result waiting on m_tready does not block pair
// accumulation; only the next result waits for the output register.
//
module cosine_similarity_engine
    import cse_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // input pairs
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // elem_a, elem_b
    input  logic                s_tlast,   // last_pair
    // results
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // similarity
    output logic [M_USER_W-1:0] m_tuser    // zero_norm, length_error
);

    // sequencer states
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_MUL_AA   = 4'd1;
    localparam logic [3:0] ST_MUL_BB   = 4'd2;
    localparam logic [3:0] ST_MUL_AB   = 4'd3;
    localparam logic [3:0] ST_ACC_DOT  = 4'd4;
    localparam logic [3:0] ST_CHECK    = 4'd5;
    localparam logic [3:0] ST_SQRT_A   = 4'd6;
    localparam logic [3:0] ST_SQRT_B   = 4'd7;
    localparam logic [3:0] ST_MUL_DEN  = 4'd8;
    localparam logic [3:0] ST_DIV_INIT = 4'd9;
    localparam logic [3:0] ST_DIV      = 4'd10;
    localparam logic [3:0] ST_SAT_Q    = 4'd11;
    localparam logic [3:0] ST_RESULT   = 4'd12;

    logic [3:0]               state_reg, state_next;
    logic signed [ELEM_W-1:0] a_reg, a_next;
    logic signed [ELEM_W-1:0] b_reg, b_next;
    logic                     last_reg, last_next;
    logic signed [ACC_W-1:0]  dot_reg, dot_next;
    logic [ACC_W-1:0]         norm_a_reg, norm_a_next;
    logic [ACC_W-1:0]         norm_b_reg, norm_b_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     ovl_reg, ovl_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [ACC_W-1:0]         x_reg, x_next;
    logic [ACC_W-1:0]         root_reg, root_next;
    logic [ACC_W-1:0]         bit_reg, bit_next;
    logic [ITER_W-1:0]        iter_reg, iter_next;
    logic [ROOT_W-1:0]        root_a_reg, root_a_next;
    logic [ROOT_W-1:0]        root_b_reg, root_b_next;
    logic [ACC_W-1:0]         den_reg, den_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic                     neg_reg, neg_next;
    logic [OUT_W-1:0]         q_reg, q_next;
    logic [OUT_W-1:0]         sim_reg, sim_next;
    logic                     zn_reg, zn_next;
    logic                     le_reg, le_next;
    logic                     m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]         m_sim_reg, m_sim_next;
    logic                     m_zn_reg, m_zn_next;
    logic                     m_le_reg, m_le_next;

    // shared unit signals
    logic signed [MUL_W-1:0]  mul_x, mul_y;
    logic signed [PROD_W-1:0] mul_prod;
    logic signed [SUM_W-1:0]  add_op, add_sum;
    logic [SUB_W-1:0]         sub_a, sub_b, sub_diff;
    logic                     sub_ge;
    logic [ACC_W-1:0]         root_step;
    logic [REM_W-1:0]         dot_mag;
    logic                     in_accept, out_load;

    assign in_accept = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_RESULT) && (!m_valid_reg || m_tready);

    // magnitude of the dot sum
    always_comb begin
        dot_mag = {dot_reg[ACC_W-1], dot_reg};
        if (dot_reg[ACC_W-1]) begin
            dot_mag = ~dot_mag + REM_W'(1);
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_x = MUL_W'(a_reg);
        mul_y = MUL_W'(a_reg);
        unique case (state_reg)
            ST_MUL_BB: begin
                mul_x = MUL_W'(b_reg);
                mul_y = MUL_W'(b_reg);
            end
            ST_MUL_AB: begin
                mul_y = MUL_W'(b_reg);
            end
            ST_MUL_DEN: begin
                mul_x = MUL_W'($signed({1'b0, root_a_reg}));
                mul_y = MUL_W'($signed({1'b0, root_b_reg}));
            end
            default: begin
            end
        endcase
    end

    // shared multiplier at full product width
    assign mul_prod = PROD_W'(mul_x) * PROD_W'(mul_y);

    // shared accumulate adder
    always_comb begin
        add_op = SUM_W'(dot_reg);
        unique case (state_reg)
            ST_MUL_BB: add_op = $signed({{(SUM_W - ACC_W){1'b0}}, norm_a_reg});
            ST_MUL_AB: add_op = $signed({{(SUM_W - ACC_W){1'b0}}, norm_b_reg});
            default:   add_op = SUM_W'(dot_reg);
        endcase
        add_sum = add_op + SUM_W'(prod_reg);
    end

    // shared subtractor for root and quotient steps
    always_comb begin
        sub_a = SUB_W'(x_reg);
        sub_b = SUB_W'(root_reg | bit_reg);
        unique case (state_reg)
            ST_DIV_INIT: begin
                sub_a = SUB_W'(dot_mag);
                sub_b = SUB_W'({prod_reg[ACC_W-1:0], 1'b0});
            end
            ST_DIV: begin
                sub_a = SUB_W'(rem_reg);
                sub_b = SUB_W'(den_reg);
            end
            default: begin
            end
        endcase
        sub_diff = sub_a - sub_b;
        sub_ge   = !sub_diff[SUB_W-1];
    end

    // one square root digit
    assign root_step = sub_ge ? ((root_reg >> 1) | bit_reg) : (root_reg >> 1);

    // sequencer and datapath next state
    always_comb begin
        state_next   = state_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        last_next    = last_reg;
        dot_next     = dot_reg;
        norm_a_next  = norm_a_reg;
        norm_b_next  = norm_b_reg;
        count_next   = count_reg;
        ovl_next     = ovl_reg;
        prod_next    = prod_reg;
        x_next       = x_reg;
        root_next    = root_reg;
        bit_next     = bit_reg;
        iter_next    = iter_reg;
        root_a_next  = root_a_reg;
        root_b_next  = root_b_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        neg_next     = neg_reg;
        q_next       = q_reg;
        sim_next     = sim_reg;
        zn_next      = zn_reg;
        le_next      = le_reg;
        m_valid_next = m_valid_reg;
        m_sim_next   = m_sim_reg;
        m_zn_next    = m_zn_reg;
        m_le_next    = m_le_reg;

        // output register drains
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg) inside
            ST_IDLE: begin
                if (in_accept) begin
                    a_next    = s_tdata[ELEM_W-1:0];
                    b_next    = s_tdata[2*ELEM_W-1:ELEM_W];
                    last_next = s_tlast;
                    if (count_reg == CNT_W'(MAX_LEN)) begin
                        // overlength pair is dropped
                        ovl_next   = 1'b1;
                        state_next = s_tlast ? ST_CHECK : ST_IDLE;
                    end else begin
                        state_next = ST_MUL_AA;
                    end
                end
            end
            ST_MUL_AA: begin
                prod_next  = mul_prod;
                state_next = ST_MUL_BB;
            end
            ST_MUL_BB: begin
                prod_next   = mul_prod;
                norm_a_next = (add_sum > NORM_MAX) ? ACC_W'(NORM_MAX) : add_sum[ACC_W-1:0];
                state_next  = ST_MUL_AB;
            end
            ST_MUL_AB: begin
                prod_next   = mul_prod;
                norm_b_next = (add_sum > NORM_MAX) ? ACC_W'(NORM_MAX) : add_sum[ACC_W-1:0];
                state_next  = ST_ACC_DOT;
            end
            ST_ACC_DOT: begin
                if (add_sum > DOT_MAX) begin
                    dot_next = ACC_W'(DOT_MAX);
                end else if (add_sum < DOT_MIN) begin
                    dot_next = ACC_W'(DOT_MIN);
                end else begin
                    dot_next = add_sum[ACC_W-1:0];
                end
                count_next = count_reg + CNT_W'(1);
                state_next = last_reg ? ST_CHECK : ST_IDLE;
            end
            ST_CHECK: begin
                sim_next = '0;
                zn_next  = 1'b0;
                le_next  = 1'b0;
                if (ovl_reg) begin
                    le_next    = 1'b1;
                    state_next = ST_RESULT;
                end else if (norm_a_reg == '0 || norm_b_reg == '0) begin
                    zn_next    = 1'b1;
                    state_next = ST_RESULT;
                end else begin
                    x_next     = norm_a_reg;
                    root_next  = '0;
                    bit_next   = ROOT_BIT_INIT;
                    iter_next  = '0;
                    state_next = ST_SQRT_A;
                end
            end
            ST_SQRT_A, ST_SQRT_B: begin
                // one digit of the bitwise square root
                if (sub_ge) begin
                    x_next = sub_diff[ACC_W-1:0];
                end
                root_next = root_step;
                bit_next  = bit_reg >> 2;
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(ROOT_W - 1)) begin
                    iter_next = '0;
                    if (state_reg == ST_SQRT_A) begin
                        root_a_next = root_step[ROOT_W-1:0];
                        x_next      = norm_b_reg;
                        root_next   = '0;
                        bit_next    = ROOT_BIT_INIT;
                        state_next  = ST_SQRT_B;
                    end else begin
                        root_b_next = root_step[ROOT_W-1:0];
                        state_next  = ST_MUL_DEN;
                    end
                end
            end
            ST_MUL_DEN: begin
                prod_next  = mul_prod;
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                den_next  = prod_reg[ACC_W-1:0];
                rem_next  = dot_mag;
                neg_next  = dot_reg[ACC_W-1];
                iter_next = '0;
                if (sub_ge) begin
                    // quotient reaches past full scale
                    q_next     = '1;
                    state_next = ST_SAT_Q;
                end else begin
                    q_next     = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // one restoring quotient bit
                q_next    = {q_reg[OUT_W-2:0], sub_ge};
                rem_next  = sub_ge ? {sub_diff[REM_W-2:0], 1'b0} : {rem_reg[REM_W-2:0], 1'b0};
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(DIV_STEPS - 1)) begin
                    state_next = ST_SAT_Q;
                end
            end
            ST_SAT_Q: begin
                if (neg_reg) begin
                    sim_next = (q_reg >= SIM_MIN) ? SIM_MIN : (~q_reg + OUT_W'(1));
                end else begin
                    sim_next = (q_reg > SIM_MAX) ? SIM_MAX : q_reg;
                end
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_sim_next   = sim_reg;
                    m_zn_next    = zn_reg;
                    m_le_next    = le_reg;
                    dot_next     = '0;
                    norm_a_next  = '0;
                    norm_b_next  = '0;
                    count_next   = '0;
                    ovl_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and accumulator registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            dot_reg     <= '0;
            norm_a_reg  <= '0;
            norm_b_reg  <= '0;
            count_reg   <= '0;
            ovl_reg     <= 1'b0;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dot_reg     <= dot_next;
            norm_a_reg  <= norm_a_next;
            norm_b_reg  <= norm_b_next;
            count_reg   <= count_next;
            ovl_reg     <= ovl_next;
            iter_reg    <= iter_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        last_reg   <= last_next;
        prod_reg   <= prod_next;
        x_reg      <= x_next;
        root_reg   <= root_next;
        bit_reg    <= bit_next;
        root_a_reg <= root_a_next;
        root_b_reg <= root_b_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        q_reg      <= q_next;
        sim_reg    <= sim_next;
        zn_reg     <= zn_next;
        le_reg     <= le_next;
        m_sim_reg  <= m_sim_next;
        m_zn_reg   <= m_zn_next;
        m_le_reg   <= m_le_next;
    end

    // ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(m_sim_reg);
    assign m_tuser  = {m_le_reg, m_zn_reg};

endmodule
